>>> hw/rtl/midi_tc_pkg.sv
// shared constants, command codes and the frame count conversion for the timecode receiver
package midi_tc_pkg;

  // field widths
  localparam int FRAME_W = 22;
  localparam int TIME_W  = 48;
  localparam int BLEN_W  = 16;
  localparam int TOUT_W  = 32;

  // command codes
  localparam logic [1:0] CMD_QUARTER = 2'd0;
  localparam logic [1:0] CMD_FULL    = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  // rate codes
  localparam logic [1:0] RATE_24   = 2'd0;
  localparam logic [1:0] RATE_25   = 2'd1;
  localparam logic [1:0] RATE_DROP = 2'd2;
  localparam logic [1:0] RATE_30   = 2'd3;

  // full-frame sysex checks
  localparam logic [7:0] SYSEX_ID   = 8'h7F;
  localparam logic [7:0] SUB_ID_TC  = 8'h01;
  localparam logic [7:0] SUB_ID_FF  = 8'h01;
  localparam logic [7:0] SYSEX_MIN  = 8'd10;

  localparam logic [2:0] LAST_NIBBLE  = 3'd7;
  localparam logic [TOUT_W-1:0] TIMEOUT_RST = 32'd48000;
  localparam logic [FRAME_W-1:0] QF_OFFSET  = 22'd2;

  // frames per hour, minute and second for each rate; drop-frame weights fold in the
  // two frames dropped every minute except each tenth
  localparam logic [22:0] HR_24 = 23'd86400,  MN_24 = 23'd1440, SC_24 = 23'd24;
  localparam logic [22:0] HR_25 = 23'd90000,  MN_25 = 23'd1500, SC_25 = 23'd25;
  localparam logic [22:0] HR_DF = 23'd107892, MN_DF = 23'd1798, SC_DF = 23'd30;
  localparam logic [22:0] HR_30 = 23'd108000, MN_30 = 23'd1800, SC_30 = 23'd30;

  // reciprocal for a six bit divide by ten
  localparam logic [15:0] RECIP_10 = 16'd205;

  // absolute frame count from hours, minutes, seconds and frames
  function automatic logic [FRAME_W-1:0] to_frames(input logic [4:0] hh,
                                                   input logic [5:0] mm,
                                                   input logic [5:0] ss,
                                                   input logic [4:0] ff,
                                                   input logic [1:0] rate);
    logic [15:0] mm_prod;
    logic [22:0] tens;
    logic [22:0] sum;
    mm_prod = 16'(mm) * RECIP_10;
    tens    = 23'(mm_prod[15:11]);
    case (rate)
      RATE_24:   sum = 23'(hh) * HR_24 + 23'(mm) * MN_24 + 23'(ss) * SC_24 + 23'(ff);
      RATE_25:   sum = 23'(hh) * HR_25 + 23'(mm) * MN_25 + 23'(ss) * SC_25 + 23'(ff);
      RATE_DROP: sum = 23'(hh) * HR_DF + 23'(mm) * MN_DF + 23'(ss) * SC_DF + 23'(ff)
                       + (tens << 1);
      RATE_30:   sum = 23'(hh) * HR_30 + 23'(mm) * MN_30 + 23'(ss) * SC_30 + 23'(ff);
      default:   sum = '0;
    endcase
    return sum[FRAME_W-1:0];
  endfunction

endpackage

>>> hw/rtl/midi_timecode_receiver.sv
// midi timecode receiver: quarter-frame and full-frame decoding with a rolling watchdog
//
// Takes one item per clock unless in_stall holds it and returns exactly one result item for
// each. An item is held in an input register, decoded against the timecode state by a single
// pass of logic (the frame count conversion is a handful of constant multiplies and adds) and
// written to a result register together with the new state. in_stall rises only while the
// result register is full and out_stall holds it. The rolling timeout is written through the
// cfg port, which is always ready, and should only be changed while no item is in flight.
module midi_timecode_receiver (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [midi_tc_pkg::TOUT_W-1:0]    cfg_data,
  // input items
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_cmd,
  input  logic [7:0]                        in_qf_byte,
  input  logic [7:0]                        in_msg_len,
  input  logic [7:0]                        in_sysex_id,
  input  logic [7:0]                        in_sub_id_one,
  input  logic [7:0]                        in_sub_id_two,
  input  logic [7:0]                        in_hour_byte,
  input  logic [7:0]                        in_minute_byte,
  input  logic [7:0]                        in_second_byte,
  input  logic [7:0]                        in_frame_byte,
  input  logic [midi_tc_pkg::TIME_W-1:0]    in_sample_time,
  input  logic [midi_tc_pkg::BLEN_W-1:0]    in_block_len,
  // result items
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [midi_tc_pkg::FRAME_W-1:0]   out_frame_count,
  output logic [1:0]                        out_frame_rate,
  output logic                              out_is_rolling,
  output logic                              out_is_reversed,
  output logic                              out_updated
);

  import midi_tc_pkg::*;

  // configuration register
  logic [TOUT_W-1:0] timeout_r;

  // input register
  logic              in_v_r;
  logic [1:0]        cmd_r;
  logic [7:0]        qf_r, len_r, sid_r, sub1_r, sub2_r;
  logic [7:0]        hr_r, mn_r, sc_r, fr_r;
  logic [TIME_W-1:0] at_r;
  logic [BLEN_W-1:0] blen_r;

  // timecode state
  logic [2:0]         exp_r, exp_nxt;
  logic [7:0]         tb_r [4];
  logic [7:0]         tb_nxt [4];
  logic [FRAME_W-1:0] total_r, total_nxt;
  logic [1:0]         rate_r, rate_nxt;
  logic               roll_r, roll_nxt;
  logic               rev_r, rev_nxt;
  logic [TIME_W-1:0]  last_r, last_nxt;
  logic               last_v_r, last_v_nxt;
  logic               upd_nxt;

  // result register
  logic               out_v_r;
  logic [FRAME_W-1:0] res_count_r;
  logic [1:0]         res_rate_r;
  logic               res_roll_r, res_rev_r, res_upd_r;

  // decode helpers
  logic [2:0]         idx;
  logic [3:0]         data;
  logic               sysex_ok;
  logic               commit;
  logic               offset;
  logic [FRAME_W-1:0] frames;
  logic [TIME_W+1:0]  diff;
  logic               advance;

  // handshake
  assign advance   = in_v_r && (!out_v_r || !out_stall);
  assign in_stall  = in_v_r && !advance;
  assign cfg_ready = 1'b1;

  assign idx      = qf_r[6:4];
  assign data     = qf_r[3:0];
  assign sysex_ok = (len_r >= SYSEX_MIN) && (sid_r == SYSEX_ID) &&
                    (sub1_r == SUB_ID_TC) && (sub2_r == SUB_ID_FF);

  // signed distance from the last timecode event to the end of the block
  assign diff = {2'b00, at_r} + (TIME_W + 2)'(blen_r) - {2'b00, last_r};

  // next state for the item in the input register
  always_comb begin
    exp_nxt    = exp_r;
    tb_nxt     = tb_r;
    rev_nxt    = rev_r;
    roll_nxt   = roll_r;
    commit     = 1'b0;
    offset     = 1'b0;
    case (cmd_r)
      CMD_QUARTER: begin
        if (idx != exp_r) begin
          if ((exp_r != 3'd0 && idx < exp_r) || (exp_r == 3'd0 && idx == LAST_NIBBLE)) begin
            rev_nxt  = 1'b1;
            roll_nxt = 1'b0;
          end
          exp_nxt = '0;
        end else begin
          if (idx == 3'd0) begin
            rev_nxt   = 1'b0;
            tb_nxt[0] = {4'h0, data};
            tb_nxt[1] = '0;
            tb_nxt[2] = '0;
            tb_nxt[3] = '0;
          end else begin
            for (int i = 0; i < 4; i++) begin
              if (idx[2:1] == 2'(i)) begin
                if (!idx[0]) tb_nxt[i] = {tb_r[i][7:4], data};
                else         tb_nxt[i] = {data, tb_r[i][3:0]};
              end
            end
          end
          if (idx == LAST_NIBBLE) begin
            commit   = 1'b1;
            offset   = 1'b1;
            roll_nxt = 1'b1;
            exp_nxt  = '0;
          end else begin
            exp_nxt = idx + 3'd1;
          end
        end
      end
      CMD_FULL: begin
        if (sysex_ok) begin
          tb_nxt[0] = {3'b000, fr_r[4:0]};
          tb_nxt[1] = {2'b00, sc_r[5:0]};
          tb_nxt[2] = {2'b00, mn_r[5:0]};
          tb_nxt[3] = {1'b0, hr_r[6:0]};
          rev_nxt   = 1'b0;
          roll_nxt  = 1'b1;
          commit    = 1'b1;
        end
      end
      CMD_TICK: begin
        if (roll_r && last_v_r && !diff[TIME_W+1] &&
            (diff[TIME_W:0] > (TIME_W + 1)'(timeout_r))) begin
          roll_nxt = 1'b0;
          rev_nxt  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // frame count conversion and commit
  always_comb begin
    frames     = to_frames(tb_nxt[3][4:0], tb_nxt[2][5:0], tb_nxt[1][5:0],
                           tb_nxt[0][4:0], tb_nxt[3][6:5]);
    total_nxt  = total_r;
    rate_nxt   = rate_r;
    last_nxt   = last_r;
    last_v_nxt = last_v_r;
    upd_nxt    = commit;
    if (commit) begin
      total_nxt  = offset ? frames + QF_OFFSET : frames;
      rate_nxt   = tb_nxt[3][6:5];
      last_nxt   = at_r;
      last_v_nxt = 1'b1;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      in_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      exp_r     <= '0;
      for (int i = 0; i < 4; i++) tb_r[i] <= '0;
      total_r   <= '0;
      rate_r    <= '0;
      roll_r    <= 1'b0;
      rev_r     <= 1'b0;
      last_r    <= '0;
      last_v_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) timeout_r <= cfg_data;
      if (!in_stall) in_v_r <= in_valid;
      if (advance) out_v_r <= 1'b1;
      else if (!out_stall) out_v_r <= 1'b0;
      if (advance) begin
        exp_r    <= exp_nxt;
        tb_r     <= tb_nxt;
        total_r  <= total_nxt;
        rate_r   <= rate_nxt;
        roll_r   <= roll_nxt;
        rev_r    <= rev_nxt;
        last_r   <= last_nxt;
        last_v_r <= last_v_nxt;
      end
    end
  end

  // item payload and result registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r  <= in_cmd;
      qf_r   <= in_qf_byte;
      len_r  <= in_msg_len;
      sid_r  <= in_sysex_id;
      sub1_r <= in_sub_id_one;
      sub2_r <= in_sub_id_two;
      hr_r   <= in_hour_byte;
      mn_r   <= in_minute_byte;
      sc_r   <= in_second_byte;
      fr_r   <= in_frame_byte;
      at_r   <= in_sample_time;
      blen_r <= in_block_len;
    end
    if (advance) begin
      res_count_r <= total_nxt;
      res_rate_r  <= rate_nxt;
      res_roll_r  <= roll_nxt;
      res_rev_r   <= rev_nxt;
      res_upd_r   <= upd_nxt;
    end
  end

  // result outputs
  assign out_valid       = out_v_r;
  assign out_frame_count = res_count_r;
  assign out_frame_rate  = res_rate_r;
  assign out_is_rolling  = res_roll_r;
  assign out_is_reversed = res_rev_r;
  assign out_updated     = res_upd_r;

endmodule

>>> verif/midi_tc_checker.sv
// result checker for the timecode receiver: tracks the timecode state and compares each result item
`timescale 1ns / 100ps
module midi_tc_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [midi_tc_pkg::TOUT_W-1:0]   cfg_data,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [1:0]                       in_cmd,
  input  logic [7:0]                       in_qf_byte,
  input  logic [7:0]                       in_msg_len,
  input  logic [7:0]                       in_sysex_id,
  input  logic [7:0]                       in_sub_id_one,
  input  logic [7:0]                       in_sub_id_two,
  input  logic [7:0]                       in_hour_byte,
  input  logic [7:0]                       in_minute_byte,
  input  logic [7:0]                       in_second_byte,
  input  logic [7:0]                       in_frame_byte,
  input  logic [midi_tc_pkg::TIME_W-1:0]   in_sample_time,
  input  logic [midi_tc_pkg::BLEN_W-1:0]   in_block_len,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [midi_tc_pkg::FRAME_W-1:0]  out_frame_count,
  input  logic [1:0]                       out_frame_rate,
  input  logic                             out_is_rolling,
  input  logic                             out_is_reversed,
  input  logic                             out_updated,
  output int                               pending,
  output int                               errors
);

  import midi_tc_pkg::*;

  typedef struct packed {
    logic [FRAME_W-1:0] count;
    logic [1:0]         rate;
    logic               rolling;
    logic               reversed;
    logic               updated;
  } tc_result_t;

  // timecode state kept alongside the block
  logic [TOUT_W-1:0]  timeout_limit;
  logic [2:0]         next_nibble;
  logic [7:0]         tc_bytes [4];
  logic [FRAME_W-1:0] frame_total;
  logic [1:0]         rate_code;
  logic               rolling;
  logic               reversed;
  logic [TIME_W-1:0]  last_commit_at;
  logic               seen_commit;
  tc_result_t         timecode_due [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // turn the four time bytes into a frame count and mark the master as running
  task automatic commit_time(logic [TIME_W-1:0] at, bit offset);
    int unsigned hh, mm, ss, ff, secs, mins, total;
    logic [1:0]  rate;
    ff   = tc_bytes[0][4:0];
    ss   = tc_bytes[1][5:0];
    mm   = tc_bytes[2][5:0];
    hh   = tc_bytes[3][4:0];
    rate = tc_bytes[3][6:5];
    secs = hh * 3600 + mm * 60 + ss;
    case (rate)
      RATE_24:   total = secs * 24 + ff;
      RATE_25:   total = secs * 25 + ff;
      RATE_DROP: begin
        // two frames dropped each minute except every tenth
        mins  = hh * 60 + mm;
        total = secs * 30 + ff - 2 * (mins - mins / 10);
      end
      default:   total = secs * 30 + ff;
    endcase
    if (offset) total += 2;
    rate_code      = rate;
    frame_total    = FRAME_W'(total);
    rolling        = 1'b1;
    last_commit_at = at;
    seen_commit    = 1'b1;
  endtask

  task automatic check_field(string label, logic [FRAME_W-1:0] want, logic [FRAME_W-1:0] got);
    if (got !== want) begin
      if (errors < 100)
        $display("%0t: %s expected %0d got %0d", $time, label, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : track
    logic [2:0]  idx;
    logic [3:0]  nib;
    logic        upd;
    longint      reach;
    tc_result_t  want;
    if (!rst_n) begin
      timeout_limit  = TIMEOUT_RST;
      next_nibble    = '0;
      tc_bytes       = '{default: '0};
      frame_total    = '0;
      rate_code      = RATE_24;
      rolling        = 1'b0;
      reversed       = 1'b0;
      last_commit_at = '0;
      seen_commit    = 1'b0;
      timecode_due.delete();
    end else begin
      // compare the result item leaving the block
      if (out_valid && !out_stall) begin
        if (timecode_due.size() == 0) begin
          if (errors < 100)
            $display("%0t: result item expected none got count %0d", $time, out_frame_count);
          errors++;
        end else begin
          want = timecode_due.pop_front();
          check_field("frame_count", want.count, out_frame_count);
          check_field("frame_rate", FRAME_W'(want.rate), FRAME_W'(out_frame_rate));
          check_field("is_rolling", FRAME_W'(want.rolling), FRAME_W'(out_is_rolling));
          check_field("is_reversed", FRAME_W'(want.reversed), FRAME_W'(out_is_reversed));
          check_field("updated", FRAME_W'(want.updated), FRAME_W'(out_updated));
        end
      end

      if (cfg_valid && cfg_ready) timeout_limit = cfg_data;

      // step the timecode state for an accepted item
      if (in_valid && !in_stall) begin
        upd = 1'b0;
        case (in_cmd)
          CMD_QUARTER: begin
            idx = in_qf_byte[6:4];
            nib = in_qf_byte[3:0];
            if (idx != next_nibble) begin
              // a step back, or a wrap to the last nibble, means reverse scrub
              if ((next_nibble != 3'd0 && idx < next_nibble) ||
                  (next_nibble == 3'd0 && idx == LAST_NIBBLE)) begin
                reversed = 1'b1;
                rolling  = 1'b0;
              end
              next_nibble = '0;
            end else begin
              if (idx == 3'd0) begin
                reversed    = 1'b0;
                tc_bytes[0] = {4'h0, nib};
                tc_bytes[1] = '0;
                tc_bytes[2] = '0;
                tc_bytes[3] = '0;
              end else if (idx[0]) begin
                tc_bytes[idx[2:1]][7:4] = nib;
              end else begin
                tc_bytes[idx[2:1]][3:0] = nib;
              end
              if (idx == LAST_NIBBLE) begin
                commit_time(in_sample_time, 1'b1);
                next_nibble = '0;
                upd         = 1'b1;
              end else begin
                next_nibble = idx + 3'd1;
              end
            end
          end
          CMD_FULL: begin
            if (in_msg_len >= SYSEX_MIN && in_sysex_id == SYSEX_ID &&
                in_sub_id_one == SUB_ID_TC && in_sub_id_two == SUB_ID_FF) begin
              tc_bytes[0] = in_frame_byte & 8'h1F;
              tc_bytes[1] = in_second_byte & 8'h3F;
              tc_bytes[2] = in_minute_byte & 8'h3F;
              tc_bytes[3] = in_hour_byte & 8'h7F;
              reversed    = 1'b0;
              commit_time(in_sample_time, 1'b0);
              upd         = 1'b1;
            end
          end
          CMD_TICK: begin
            // signed distance from the last commit to the end of the block
            reach = longint'({16'h0, in_sample_time}) + longint'({48'h0, in_block_len})
                    - longint'({16'h0, last_commit_at});
            if (rolling && seen_commit && reach > longint'({32'h0, timeout_limit})) begin
              rolling  = 1'b0;
              reversed = 1'b0;
            end
          end
          default: ;
        endcase
        timecode_due.push_back('{frame_total, rate_code, rolling, reversed, upd});
      end
    end
    pending = timecode_due.size();
  end

endmodule

>>> verif/tb_top.sv
// testbench top for the timecode receiver: clock, reset, stimulus phases and the verdict
`timescale 1ns / 100ps
module tb_top;
  import midi_tc_pkg::*;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 200;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [7:0]        qf;
    logic [7:0]        len;
    logic [7:0]        id;
    logic [7:0]        sub1;
    logic [7:0]        sub2;
    logic [7:0]        hr;
    logic [7:0]        mn;
    logic [7:0]        sc;
    logic [7:0]        fr;
    logic [TIME_W-1:0] at;
    logic [BLEN_W-1:0] blen;
  } tc_event_t;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                cfg_valid      = 1'b0;
  logic                cfg_ready;
  logic [TOUT_W-1:0]   cfg_data       = '0;
  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic [1:0]          in_cmd         = CMD_NONE;
  logic [7:0]          in_qf_byte     = '0;
  logic [7:0]          in_msg_len     = '0;
  logic [7:0]          in_sysex_id    = '0;
  logic [7:0]          in_sub_id_one  = '0;
  logic [7:0]          in_sub_id_two  = '0;
  logic [7:0]          in_hour_byte   = '0;
  logic [7:0]          in_minute_byte = '0;
  logic [7:0]          in_second_byte = '0;
  logic [7:0]          in_frame_byte  = '0;
  logic [TIME_W-1:0]   in_sample_time = '0;
  logic [BLEN_W-1:0]   in_block_len   = '0;
  logic                out_valid;
  logic                out_stall      = 1'b0;
  logic [FRAME_W-1:0]  out_frame_count;
  logic [1:0]          out_frame_rate;
  logic                out_is_rolling;
  logic                out_is_reversed;
  logic                out_updated;
  int                  pending;
  int                  errors;

  int                  send_idle_pct  = 0;
  int                  recv_stall_pct = 0;
  int                  sent_count     = 0;
  int                  cycle_count    = 0;
  logic [TIME_W-1:0]   now_time       = 48'd100000;

  midi_timecode_receiver dut (.*);
  midi_tc_checker result_check (.*);

  always #5 clk = ~clk;

  // receiver stall, redrawn every cycle
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // random item; the time mostly moves forward, now and then jumps anywhere
  function automatic tc_event_t fresh_event(logic [1:0] cmd);
    tc_event_t ev;
    ev.cmd  = cmd;
    ev.qf   = 8'($urandom);
    ev.len  = 8'($urandom);
    ev.id   = 8'($urandom);
    ev.sub1 = 8'($urandom);
    ev.sub2 = 8'($urandom);
    ev.hr   = 8'($urandom);
    ev.mn   = 8'($urandom);
    ev.sc   = 8'($urandom);
    ev.fr   = 8'($urandom);
    ev.blen = BLEN_W'($urandom);
    if ($urandom_range(19) == 0) begin
      ev.at = {16'($urandom), $urandom};
    end else begin
      now_time = now_time + TIME_W'($urandom_range(4000));
      ev.at    = now_time;
    end
    return ev;
  endfunction

  function automatic tc_event_t valid_sysex();
    tc_event_t ev;
    ev      = fresh_event(CMD_FULL);
    ev.len  = 8'($urandom_range(255, 10));
    ev.id   = SYSEX_ID;
    ev.sub1 = SUB_ID_TC;
    ev.sub2 = SUB_ID_FF;
    return ev;
  endfunction

  // present one item after a random gap and hold it until taken
  task automatic issue(tc_event_t ev);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_cmd         = ev.cmd;
    in_qf_byte     = ev.qf;
    in_msg_len     = ev.len;
    in_sysex_id    = ev.id;
    in_sub_id_one  = ev.sub1;
    in_sub_id_two  = ev.sub2;
    in_hour_byte   = ev.hr;
    in_minute_byte = ev.mn;
    in_second_byte = ev.sc;
    in_frame_byte  = ev.fr;
    in_sample_time = ev.at;
    in_block_len   = ev.blen;
    in_valid       = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (ev.cmd != CMD_NONE) sent_count++;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_timeout(logic [TOUT_W-1:0] value);
    drain();
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    repeat (2) @(negedge clk);
  endtask

  task automatic random_burst();
    tc_event_t ev;
    int        pick;
    int        cut;
    pick = $urandom_range(99);
    if (pick < 45) begin
      // quarter-frame run with random content, now and then broken at one nibble
      cut = ($urandom_range(9) == 0) ? $urandom_range(7) : 8;
      for (int n = 0; n < 8; n++) begin
        ev         = fresh_event(CMD_QUARTER);
        ev.qf[6:4] = (n == cut) ? 3'($urandom) : 3'(n);
        issue(ev);
      end
    end else if (pick < 60) begin
      issue(valid_sysex());
    end else if (pick < 70) begin
      // full frame failing one header check
      ev = valid_sysex();
      case ($urandom_range(3))
        0:       ev.len  = 8'($urandom_range(9));
        1:       ev.id   = 8'($urandom);
        2:       ev.sub1 = 8'($urandom);
        default: ev.sub2 = 8'($urandom);
      endcase
      issue(ev);
    end else if (pick < 90) begin
      issue(fresh_event(CMD_TICK));
    end else begin
      issue(fresh_event(2'($urandom)));
    end
  endtask

  initial begin
    tc_event_t         ev;
    logic [7:0]        broken_run [6];
    logic [TOUT_W-1:0] timeouts [PHASES];
    broken_run = '{8'h00, 8'h35, 8'h70, 8'h09, 8'h12, 8'h00};
    timeouts   = '{TIMEOUT_RST, 32'd0, 32'd1000, 32'hFFFF_FFFF,
                   32'd20000, 32'h7FFF_FFFF, 32'd5000, 32'd48000};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // ignored command with every field at its top value
    ev     = '1;
    ev.cmd = CMD_NONE;
    issue(ev);
    // tick before any timecode: nothing to clear
    ev      = fresh_event(CMD_TICK);
    ev.at   = '0;
    ev.blen = '1;
    issue(ev);
    // full quarter-frame run with every field at its top, 30 fps
    for (int n = 0; n < 8; n++) begin
      ev    = fresh_event(CMD_QUARTER);
      ev.qf = {1'b1, 3'(n), 4'hF};
      ev.at = 48'd1000;
      issue(ev);
    end
    // tick inside the timeout keeps rolling, a late one clears it
    ev      = fresh_event(CMD_TICK);
    ev.at   = 48'd1000;
    ev.blen = 16'd100;
    issue(ev);
    ev      = fresh_event(CMD_TICK);
    ev.at   = 48'd60000;
    ev.blen = '0;
    issue(ev);
    // drop-frame full frame at the shortest accepted length, top values
    ev     = valid_sysex();
    ev.len = SYSEX_MIN;
    ev.hr  = 8'hDF;
    ev.mn  = '1;
    ev.sc  = '1;
    ev.fr  = '1;
    ev.at  = 48'd70000;
    issue(ev);
    // rejected full frames: one byte short, wrong id, wrong sub id
    ev     = valid_sysex();
    ev.len = SYSEX_MIN - 8'd1;
    issue(ev);
    ev    = valid_sysex();
    ev.id = SYSEX_ID ^ 8'h01;
    issue(ev);
    ev      = valid_sysex();
    ev.sub2 = SUB_ID_FF + 8'd1;
    issue(ev);
    // skip ahead, wrap to the last nibble, then step back
    foreach (broken_run[k]) begin
      ev    = fresh_event(CMD_QUARTER);
      ev.qf = broken_run[k];
      issue(ev);
    end
    // commit at the end of the time range, then a tick at zero: negative distance
    ev    = valid_sysex();
    ev.hr = 8'h20;
    ev.mn = '0;
    ev.sc = '0;
    ev.fr = '0;
    ev.at = '1;
    issue(ev);
    ev      = fresh_event(CMD_TICK);
    ev.at   = '0;
    ev.blen = '0;
    issue(ev);

    // random phases, each with its own timeout and idling pattern
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) load_timeout(timeouts[p]);
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      sent_count = 0;
      while (sent_count < PHASE_ITEMS) random_burst();
    end

    drain();
    repeat (8) @(negedge clk);
    if (errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/midi_tc_pkg.sv
hw/rtl/midi_timecode_receiver.sv
verif/midi_tc_checker.sv
verif/tb_top.sv
